@@ hw/rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Shared types and codes for the complex arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    // Fixed port field widths
    localparam int FIELD_BITS  = 32;
    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 2;

    // Parameter defaults
    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    // Operation codes
    localparam logic [OP_BITS-1:0] OP_ADD = 2'd0;
    localparam logic [OP_BITS-1:0] OP_SUB = 2'd1;
    localparam logic [OP_BITS-1:0] OP_MUL = 2'd2;
    localparam logic [OP_BITS-1:0] OP_DIV = 2'd3;

    // Status codes
    localparam logic [STATUS_BITS-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DIV0 = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OVF  = 2'd2;

    // Control that travels with each request down the pipeline
    typedef struct packed {
        logic               valid;
        logic [OP_BITS-1:0] op;
        logic               dz;
        logic               ovf_re;
        logic               ovf_im;
        logic               neg_re;
        logic               neg_im;
    } cau_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/cau_mult.sv @@
// ----------------------------------------------------------------------------
// cau_mult
// Operand register, then the cross and square products plus add/sub sums.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_mult
    import cau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [OP_BITS-1:0]            operation,
    input  wire logic [FIELD_BITS-1:0]         a_real,
    input  wire logic [FIELD_BITS-1:0]         a_imag,
    input  wire logic [FIELD_BITS-1:0]         b_real,
    input  wire logic [FIELD_BITS-1:0]         b_imag,
    output cau_ctrl_t                          ctrl_o,
    output logic signed [2*WORD_BITS-1:0]      ac_o,
    output logic signed [2*WORD_BITS-1:0]      bd_o,
    output logic signed [2*WORD_BITS-1:0]      bc_o,
    output logic signed [2*WORD_BITS-1:0]      ad_o,
    output logic signed [2*WORD_BITS-1:0]      cc_o,
    output logic signed [2*WORD_BITS-1:0]      dd_o,
    output logic signed [WORD_BITS:0]          sum_re_o,
    output logic signed [WORD_BITS:0]          sum_im_o
);

    localparam int W = WORD_BITS;

    cau_ctrl_t             c1_reg, c1_next;
    cau_ctrl_t             c2_reg;
    logic signed [W-1:0]   a_reg, b_reg, c_reg, d_reg;
    logic signed [2*W-1:0] ac_reg, bd_reg, bc_reg, ad_reg, cc_reg, dd_reg;
    logic signed [W:0]     sre_reg, sim_reg, sre_next, sim_next;

    // Build the control word for a new request
    always_comb
    begin
        c1_next        = '0;
        c1_next.valid  = in_valid;
        c1_next.op     = operation;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
        end
        else if (en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
        end
    end

    // Add or subtract the operand parts
    always_comb
    begin
        if (c1_reg.op == OP_SUB)
        begin
            sre_next = {a_reg[W-1], a_reg} - {c_reg[W-1], c_reg};
            sim_next = {b_reg[W-1], b_reg} - {d_reg[W-1], d_reg};
        end
        else
        begin
            sre_next = {a_reg[W-1], a_reg} + {c_reg[W-1], c_reg};
            sim_next = {b_reg[W-1], b_reg} + {d_reg[W-1], d_reg};
        end
    end

    // Capture operands, then products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg   <= a_real[W-1:0];
            b_reg   <= a_imag[W-1:0];
            c_reg   <= b_real[W-1:0];
            d_reg   <= b_imag[W-1:0];
            ac_reg  <= a_reg * c_reg;
            bd_reg  <= b_reg * d_reg;
            bc_reg  <= b_reg * c_reg;
            ad_reg  <= a_reg * d_reg;
            cc_reg  <= c_reg * c_reg;
            dd_reg  <= d_reg * d_reg;
            sre_reg <= sre_next;
            sim_reg <= sim_next;
        end
    end

    assign ctrl_o   = c2_reg;
    assign ac_o     = ac_reg;
    assign bd_o     = bd_reg;
    assign bc_o     = bc_reg;
    assign ad_o     = ad_reg;
    assign cc_o     = cc_reg;
    assign dd_o     = dd_reg;
    assign sum_re_o = sre_reg;
    assign sum_im_o = sim_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cau_prep.sv @@
// ----------------------------------------------------------------------------
// cau_prep
// Combine products into sign and magnitude, then scale for multiply or set up
// the dividend and overflow check for divide.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_prep
    import cau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire cau_ctrl_t                              ctrl_i,
    input  wire logic signed [2*WORD_BITS-1:0]          ac_i,
    input  wire logic signed [2*WORD_BITS-1:0]          bd_i,
    input  wire logic signed [2*WORD_BITS-1:0]          bc_i,
    input  wire logic signed [2*WORD_BITS-1:0]          ad_i,
    input  wire logic signed [2*WORD_BITS-1:0]          cc_i,
    input  wire logic signed [2*WORD_BITS-1:0]          dd_i,
    input  wire logic signed [WORD_BITS:0]              sum_re_i,
    input  wire logic signed [WORD_BITS:0]              sum_im_i,
    output cau_ctrl_t                                   ctrl_o,
    output logic [2*WORD_BITS-1:0]                      q_re_o,
    output logic [2*WORD_BITS-1:0]                      q_im_o,
    output logic [3*WORD_BITS+FRAC_BITS+1:0]            rem_re_o,
    output logic [3*WORD_BITS+FRAC_BITS+1:0]            rem_im_o,
    output logic [2*WORD_BITS-1:0]                      den_o
);

    localparam int W  = WORD_BITS;
    localparam int MW = 2 * WORD_BITS;
    localparam int DW = 3 * WORD_BITS + FRAC_BITS + 2;

    cau_ctrl_t          c3_reg, c3_next, c4_reg, c4_next;
    logic signed [MW:0] sre, sim;
    logic [MW-1:0]      mre_reg, mim_reg, mre_next, mim_next;
    logic [MW-1:0]      den_reg, den_next, den4_reg;
    logic [MW-1:0]      qre_reg, qim_reg, qre_next, qim_next;
    logic [DW-1:0]      rre_reg, rim_reg, rre_next, rim_next;
    logic [DW-1:0]      lim;

    // Form the signed sums for each operation
    always_comb
    begin
        case (ctrl_i.op)
            OP_MUL:
            begin
                sre = {ac_i[MW-1], ac_i} - {bd_i[MW-1], bd_i};
                sim = {bc_i[MW-1], bc_i} + {ad_i[MW-1], ad_i};
            end
            OP_DIV:
            begin
                sre = {ac_i[MW-1], ac_i} + {bd_i[MW-1], bd_i};
                sim = {bc_i[MW-1], bc_i} - {ad_i[MW-1], ad_i};
            end
            default:
            begin
                sre = (MW+1)'(sum_re_i);
                sim = (MW+1)'(sum_im_i);
            end
        endcase
    end

    // Split into sign and magnitude, sum the squares
    always_comb
    begin
        c3_next        = ctrl_i;
        c3_next.neg_re = sre[MW];
        c3_next.neg_im = sim[MW];
        mre_next       = sre[MW] ? MW'(-sre) : sre[MW-1:0];
        mim_next       = sim[MW] ? MW'(-sim) : sim[MW-1:0];
        den_next       = MW'($unsigned(cc_i) + $unsigned(dd_i));
    end

    // Scale for multiply, build dividend and range check for divide
    always_comb
    begin
        c4_next = c3_reg;
        lim     = DW'(den_reg) << (W + 1);
        rre_next = DW'(mre_reg) << FRAC_BITS;
        rim_next = DW'(mim_reg) << FRAC_BITS;
        qre_next = mre_reg;
        qim_next = mim_reg;
        case (c3_reg.op)
            OP_MUL:
            begin
                qre_next = mre_reg >> FRAC_BITS;
                qim_next = mim_reg >> FRAC_BITS;
            end
            OP_DIV:
            begin
                qre_next       = '0;
                qim_next       = '0;
                c4_next.dz     = (den_reg == '0);
                c4_next.ovf_re = (rre_next >= lim);
                c4_next.ovf_im = (rim_next >= lim);
            end
            default:
            begin
                qre_next = mre_reg;
                qim_next = mim_reg;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c3_reg <= '0;
            c4_reg <= '0;
        end
        else if (en)
        begin
            c3_reg <= c3_next;
            c4_reg <= c4_next;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mre_reg  <= mre_next;
            mim_reg  <= mim_next;
            den_reg  <= den_next;
            qre_reg  <= qre_next;
            qim_reg  <= qim_next;
            rre_reg  <= rre_next;
            rim_reg  <= rim_next;
            den4_reg <= den_reg;
        end
    end

    assign ctrl_o   = c4_reg;
    assign q_re_o   = qre_reg;
    assign q_im_o   = qim_reg;
    assign rem_re_o = rre_reg;
    assign rem_im_o = rim_reg;
    assign den_o    = den4_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cau_div_stage.sv @@
// ----------------------------------------------------------------------------
// cau_div_stage
// One restoring-division step: decide one quotient bit for both parts.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_div_stage
    import cau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BIT_POS   = 0
)
(
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire cau_ctrl_t                              ctrl_i,
    input  wire logic [2*WORD_BITS-1:0]                 q_re_i,
    input  wire logic [2*WORD_BITS-1:0]                 q_im_i,
    input  wire logic [3*WORD_BITS+FRAC_BITS+1:0]       rem_re_i,
    input  wire logic [3*WORD_BITS+FRAC_BITS+1:0]       rem_im_i,
    input  wire logic [2*WORD_BITS-1:0]                 den_i,
    output cau_ctrl_t                                   ctrl_o,
    output logic [2*WORD_BITS-1:0]                      q_re_o,
    output logic [2*WORD_BITS-1:0]                      q_im_o,
    output logic [3*WORD_BITS+FRAC_BITS+1:0]            rem_re_o,
    output logic [3*WORD_BITS+FRAC_BITS+1:0]            rem_im_o,
    output logic [2*WORD_BITS-1:0]                      den_o
);

    localparam int MW = 2 * WORD_BITS;
    localparam int DW = 3 * WORD_BITS + FRAC_BITS + 2;
    localparam logic [MW-1:0] QBIT = MW'(1) << BIT_POS;

    cau_ctrl_t     ctrl_reg;
    logic [MW-1:0] qre_reg, qim_reg, qre_next, qim_next, den_reg;
    logic [DW-1:0] rre_reg, rim_reg, rre_next, rim_next, trial;
    logic          take_re, take_im;

    // Compare and subtract the shifted divisor
    always_comb
    begin
        trial    = DW'(den_i) << BIT_POS;
        take_re  = (ctrl_i.op == OP_DIV) && (rem_re_i >= trial);
        take_im  = (ctrl_i.op == OP_DIV) && (rem_im_i >= trial);
        rre_next = take_re ? rem_re_i - trial : rem_re_i;
        rim_next = take_im ? rem_im_i - trial : rem_im_i;
        qre_next = take_re ? (q_re_i | QBIT) : q_re_i;
        qim_next = take_im ? (q_im_i | QBIT) : q_im_i;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_i;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qre_reg <= qre_next;
            qim_reg <= qim_next;
            rre_reg <= rre_next;
            rim_reg <= rim_next;
            den_reg <= den_i;
        end
    end

    assign ctrl_o   = ctrl_reg;
    assign q_re_o   = qre_reg;
    assign q_im_o   = qim_reg;
    assign rem_re_o = rre_reg;
    assign rem_im_o = rim_reg;
    assign den_o    = den_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cau_sat.sv @@
// ----------------------------------------------------------------------------
// cau_sat
// Clamp magnitudes to the word range, apply sign, set status; output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cau_sat
    import cau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire cau_ctrl_t                     ctrl_i,
    input  wire logic [2*WORD_BITS-1:0]        q_re_i,
    input  wire logic [2*WORD_BITS-1:0]        q_im_i,
    output logic                               out_valid,
    output logic [FIELD_BITS-1:0]              result_real,
    output logic [FIELD_BITS-1:0]              result_imag,
    output logic [STATUS_BITS-1:0]             status
);

    localparam int W  = WORD_BITS;
    localparam int MW = 2 * WORD_BITS;
    localparam logic [MW-1:0] NEG_LIM = MW'(1) << (W - 1);
    localparam logic [MW-1:0] POS_LIM = NEG_LIM - MW'(1);

    logic                   valid_reg;
    logic [FIELD_BITS-1:0]  re_reg, im_reg, re_next, im_next;
    logic [STATUS_BITS-1:0] st_reg, st_next;
    logic signed [W-1:0]    vre, vim;
    logic                   sat_re, sat_im;

    // Clamp one part given sign, magnitude and the divider range flag
    function automatic logic [W:0] clamp(input logic neg, input logic [MW-1:0] mag,
                                         input logic big);
        logic [W-1:0] v;
        logic         s;
        begin
            s = 1'b0;
            if (neg)
            begin
                if (big || (mag > NEG_LIM))
                begin
                    v = NEG_LIM[W-1:0];
                    s = 1'b1;
                end
                else
                begin
                    v = W'(-mag);
                end
            end
            else
            begin
                if (big || (mag > POS_LIM))
                begin
                    v = POS_LIM[W-1:0];
                    s = 1'b1;
                end
                else
                begin
                    v = mag[W-1:0];
                end
            end
            clamp = {s, v};
        end
    endfunction

    // Saturate and select the status
    always_comb
    begin
        {sat_re, vre} = clamp(ctrl_i.neg_re, q_re_i, ctrl_i.ovf_re);
        {sat_im, vim} = clamp(ctrl_i.neg_im, q_im_i, ctrl_i.ovf_im);
        re_next = FIELD_BITS'(vre);
        im_next = FIELD_BITS'(vim);
        st_next = (sat_re || sat_im) ? ST_OVF : ST_OK;
        if (ctrl_i.dz)
        begin
            re_next = '0;
            im_next = '0;
            st_next = ST_DIV0;
        end
    end

    // Hold output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= ctrl_i.valid;
        end
    end

    // Capture result
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            st_reg <= st_next;
        end
    end

    assign out_valid   = valid_reg;
    assign result_real = re_reg;
    assign result_imag = im_reg;
    assign status      = st_reg;

endmodule

`default_nettype wire

@@ hw/rtl/complex_arithmetic_unit_top.sv @@
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Pipelined complex add, subtract, multiply and divide in signed fixed point.
//
// Input channel: in_valid / in_stall with operation and the two operands.
// Output channel: out_valid / out_stall with result_real, result_imag, status.
// A request moves when valid is high and stall is low at a rising edge.
//
// Every request passes four operand/product/prep stages, then the divider
// with one quotient bit per stage over WORD_BITS + 1 stages, then the output
// stage. A new request enters each cycle while the pipeline is not frozen.
// All operations pass the same stages, so results leave in order.
//
// Reset clears every valid bit; the pipeline is empty afterwards. While the
// output holds a result and out_stall is high, the whole pipeline freezes
// and in_stall is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module complex_arithmetic_unit_top
    import cau_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [OP_BITS-1:0]        operation,
    input  wire logic [FIELD_BITS-1:0]     a_real,
    input  wire logic [FIELD_BITS-1:0]     a_imag,
    input  wire logic [FIELD_BITS-1:0]     b_real,
    input  wire logic [FIELD_BITS-1:0]     b_imag,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [FIELD_BITS-1:0]          result_real,
    output logic [FIELD_BITS-1:0]          result_imag,
    output logic [STATUS_BITS-1:0]         status
);

    localparam int W      = WORD_BITS;
    localparam int MW     = 2 * WORD_BITS;
    localparam int DW     = 3 * WORD_BITS + FRAC_BITS + 2;
    localparam int NSTAGE = WORD_BITS + 1;

    logic                   en;
    cau_ctrl_t              m_ctrl;
    logic signed [MW-1:0]   ac, bd, bc, ad, cc, dd;
    logic signed [W:0]      sum_re, sum_im;

    cau_ctrl_t              d_ctrl [0:NSTAGE];
    logic [MW-1:0]          d_qre  [0:NSTAGE];
    logic [MW-1:0]          d_qim  [0:NSTAGE];
    logic [DW-1:0]          d_rre  [0:NSTAGE];
    logic [DW-1:0]          d_rim  [0:NSTAGE];
    logic [MW-1:0]          d_den  [0:NSTAGE];

    // Freeze the pipeline while a result waits on a stalled receiver
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    cau_mult #(
        .WORD_BITS (WORD_BITS)
    ) u_mult (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .operation (operation),
        .a_real    (a_real),
        .a_imag    (a_imag),
        .b_real    (b_real),
        .b_imag    (b_imag),
        .ctrl_o    (m_ctrl),
        .ac_o      (ac),
        .bd_o      (bd),
        .bc_o      (bc),
        .ad_o      (ad),
        .cc_o      (cc),
        .dd_o      (dd),
        .sum_re_o  (sum_re),
        .sum_im_o  (sum_im)
    );

    cau_prep #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ctrl_i   (m_ctrl),
        .ac_i     (ac),
        .bd_i     (bd),
        .bc_i     (bc),
        .ad_i     (ad),
        .cc_i     (cc),
        .dd_i     (dd),
        .sum_re_i (sum_re),
        .sum_im_i (sum_im),
        .ctrl_o   (d_ctrl[0]),
        .q_re_o   (d_qre[0]),
        .q_im_o   (d_qim[0]),
        .rem_re_o (d_rre[0]),
        .rem_im_o (d_rim[0]),
        .den_o    (d_den[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar i = 0; i < NSTAGE; i++)
    begin : g_div
        cau_div_stage #(
            .WORD_BITS (WORD_BITS),
            .FRAC_BITS (FRAC_BITS),
            .BIT_POS   (WORD_BITS - i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .ctrl_i   (d_ctrl[i]),
            .q_re_i   (d_qre[i]),
            .q_im_i   (d_qim[i]),
            .rem_re_i (d_rre[i]),
            .rem_im_i (d_rim[i]),
            .den_i    (d_den[i]),
            .ctrl_o   (d_ctrl[i+1]),
            .q_re_o   (d_qre[i+1]),
            .q_im_o   (d_qim[i+1]),
            .rem_re_o (d_rre[i+1]),
            .rem_im_o (d_rim[i+1]),
            .den_o    (d_den[i+1])
        );
    end

    cau_sat #(
        .WORD_BITS (WORD_BITS)
    ) u_sat (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .ctrl_i      (d_ctrl[NSTAGE]),
        .q_re_i      (d_qre[NSTAGE]),
        .q_im_i      (d_qim[NSTAGE]),
        .out_valid   (out_valid),
        .result_real (result_real),
        .result_imag (result_imag),
        .status      (status)
    );

    // A divide-by-zero result is all zero
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_DIV0) |-> (result_real == '0) && (result_imag == '0))
        else $error("divide-by-zero result not zero");

    // Status carries only defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK) || (status == ST_DIV0) || (status == ST_OVF))
        else $error("undefined status code");

    // Results stay inside the word range, sign-extended into the field
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_real == FIELD_BITS'($signed(result_real[W-1:0])))
                   && (result_imag == FIELD_BITS'($signed(result_imag[W-1:0]))))
        else $error("result outside word range");

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks complex_arithmetic_unit_top against a behavioral predictor of its
// signed fixed-point add, subtract, multiply and divide. Directed extremes
// come first, then random requests with random idling and backpressure.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import cau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WB = 32;
    localparam int FB = 16;
    localparam int WATCHDOG_CYCLES = 20000;

    typedef struct {
        logic [OP_BITS-1:0]    op;
        logic [FIELD_BITS-1:0] ar, ai, br, bi;
    } cplx_req_t;

    typedef struct {
        logic [FIELD_BITS-1:0]  re, im;
        logic [STATUS_BITS-1:0] st;
    } cplx_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [OP_BITS-1:0] operation = '0;
    logic [FIELD_BITS-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [FIELD_BITS-1:0] result_real, result_imag;
    logic [STATUS_BITS-1:0] status;

    cplx_req_t pending_reqs[$];
    cplx_res_t expected_results[$];
    bit all_queued = 0;
    bit quiet_phase = 0;
    bit hold_phase = 0;
    bit in_accepted = 0;
    int errors = 0;
    int idle_cycles = 0;

    complex_arithmetic_unit_top dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operation(operation), .a_real(a_real), .a_imag(a_imag),
        .b_real(b_real), .b_imag(b_imag),
        .out_valid(out_valid), .out_stall(out_stall),
        .result_real(result_real), .result_imag(result_imag), .status(status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Clamp a signed value to the word range; flag overflow
    function automatic logic [FIELD_BITS-1:0] clamp_part(logic signed [127:0] v,
                                                         ref bit ovf);
        logic signed [127:0] hi, lo;
        hi = (128'sd1 <<< (WB - 1)) - 1;
        lo = -(128'sd1 <<< (WB - 1));
        if (v > hi)
        begin
            ovf = 1;
            v = hi;
        end
        else if (v < lo)
        begin
            ovf = 1;
            v = lo;
        end
        return v[FIELD_BITS-1:0];
    endfunction

    // Truncate a signed value toward zero after a right shift
    function automatic logic signed [127:0] shift_trunc(logic signed [127:0] v);
        logic signed [127:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> FB;
        return (v < 0) ? -m : m;
    endfunction

    // Signed divide scaled by 2^FB, truncated, with the divider's cap
    function automatic logic signed [127:0] scaled_quot(logic signed [127:0] num,
                                                        logic signed [127:0] den);
        logic signed [127:0] m, q;
        m = (num < 0) ? -num : num;
        q = (m <<< FB) / den;
        if (q >= (128'sd1 <<< 63))
            q = 128'sd1 <<< 62;
        return (num < 0) ? -q : q;
    endfunction

    function automatic cplx_res_t predict_complex(cplx_req_t r);
        cplx_res_t res;
        logic signed [127:0] a, b, c, d, re, im, den;
        bit ovf;
        a = $signed(r.ar);
        b = $signed(r.ai);
        c = $signed(r.br);
        d = $signed(r.bi);
        ovf = 0;
        res.st = ST_OK;
        case (r.op)
            OP_ADD:
            begin
                re = a + c;
                im = b + d;
            end
            OP_SUB:
            begin
                re = a - c;
                im = b - d;
            end
            OP_MUL:
            begin
                re = shift_trunc(a * c - b * d);
                im = shift_trunc(b * c + a * d);
            end
            default:
            begin
                den = c * c + d * d;
                if (den == 0)
                begin
                    res.re = '0;
                    res.im = '0;
                    res.st = ST_DIV0;
                    return res;
                end
                re = scaled_quot(a * c + b * d, den);
                im = scaled_quot(b * c - a * d, den);
            end
        endcase
        res.re = clamp_part(re, ovf);
        res.im = clamp_part(im, ovf);
        if (ovf)
            res.st = ST_OVF;
        return res;
    endfunction

    function automatic logic [FIELD_BITS-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 | $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 8) - 4;
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_req(logic [OP_BITS-1:0] op, logic [31:0] ar, logic [31:0] ai,
                             logic [31:0] br, logic [31:0] bi);
        cplx_req_t r;
        r.op = op;
        r.ar = ar;
        r.ai = ai;
        r.br = br;
        r.bi = bi;
        pending_reqs.push_back(r);
    endtask

    // Fill the request queue: directed cases then random
    initial
    begin
        logic [OP_BITS-1:0] ops[4];
        ops = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
        foreach (ops[k])
        begin
            queue_req(ops[k], 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
            queue_req(ops[k], 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            queue_req(ops[k], 32'h0001_8000, 32'hffff_4000, 32'h0000_0001, 32'hffff_ffff);
        end
        queue_req(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
        queue_req(OP_DIV, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_0001, 32'h0);
        queue_req(OP_DIV, 32'hffff_ffff, 32'h0000_0003, 32'h0000_0002, 32'h0);
        queue_req(OP_MUL, 32'hffff_ffff, 32'h0, 32'h0000_0001, 32'h0);
        queue_req(OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 32'h0000_0001, 32'h0000_0001);
        queue_req(OP_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h8000_0000);
        repeat (1030)
            queue_req(2'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                      rand_operand(), rand_operand());
        all_queued = 1;
    end

    // Reset, then pick the hold and quiet stretches
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;
        repeat (100) @(posedge clk);
        hold_phase = 1;
        repeat (300) @(posedge clk);
        quiet_phase = 1;
        repeat (400) @(posedge clk);
        quiet_phase = 0;
    end

    // Drive requests at the falling edge; hold while stalled
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_accepted))
        begin
            if (in_accepted)
                void'(pending_reqs.pop_front());
            if (pending_reqs.size() > 0 && (quiet_phase || $urandom_range(0, 99) >= 31))
            begin
                in_valid <= 1'b1;
                operation <= pending_reqs[0].op;
                a_real <= pending_reqs[0].ar;
                a_imag <= pending_reqs[0].ai;
                b_real <= pending_reqs[0].br;
                b_imag <= pending_reqs[0].bi;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver stall: one long hold-off, none in the quiet stretch, otherwise random
    always @(negedge clk)
    begin : receiver
        int hold_left;
        bit hold_done;
        if (hold_phase && !hold_done)
        begin
            hold_done = 1;
            hold_left = 200;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet_phase && ($urandom_range(0, 99) < 31);
    end

    // Predict at input acceptance, compare at output acceptance
    always @(posedge clk)
    begin
        cplx_req_t r;
        cplx_res_t e;
        bit busy;
        busy = 1'b0;
        in_accepted <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
        begin
            r.op = operation;
            r.ar = a_real;
            r.ai = a_imag;
            r.br = b_real;
            r.bi = b_imag;
            expected_results.push_back(predict_complex(r));
            busy = 1'b1;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            busy = 1'b1;
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result re=%h im=%h st=%0d",
                         $time, result_real, result_imag, status);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (result_real !== e.re)
                begin
                    $display("%0t: result_real expected %h actual %h",
                             $time, e.re, result_real);
                    errors++;
                end
                if (result_imag !== e.im)
                begin
                    $display("%0t: result_imag expected %h actual %h",
                             $time, e.im, result_imag);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    errors++;
                end
            end
        end
        idle_cycles <= busy ? 0 : idle_cycles + 1;
    end

    // Finish once drained, or on the watchdog
    initial
    begin
        wait (rst_n);
        while (!(all_queued && pending_reqs.size() == 0 && !in_valid
                 && expected_results.size() == 0) && idle_cycles < WATCHDOG_CYCLES)
            @(posedge clk);
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("complex_arithmetic_unit_top test failed");
            $finish;
        end
        else
        begin
            repeat (60) @(posedge clk);
            if (errors == 0 && expected_results.size() == 0)
                $display("complex_arithmetic_unit_top test passed");
            else
                $display("complex_arithmetic_unit_top test failed");
            $finish;
        end
    end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/cau_pkg.sv
hw/rtl/cau_mult.sv
hw/rtl/cau_prep.sv
hw/rtl/cau_div_stage.sv
hw/rtl/cau_sat.sv
hw/rtl/complex_arithmetic_unit_top.sv
sim/testbench.sv
